// ===== design/assert_macros.svh =====
// assertion helpers used by the checker file pls_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while in reset
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, quiet while in reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/pls_pkg.sv =====
`default_nettype none
package pls_pkg;
	localparam int DW = 32;
	localparam int FB = 16;
	localparam int IN_W = 96;
	localparam int OUT_W = 104;
	localparam int CFG_IW = 3;

	localparam logic [CFG_IW-1:0] REG_KC = 3'd0;
	localparam logic [CFG_IW-1:0] REG_KI = 3'd1;
	localparam logic [CFG_IW-1:0] REG_KD = 3'd2;
	localparam logic [CFG_IW-1:0] REG_TF = 3'd3;
	localparam logic [CFG_IW-1:0] REG_LO = 3'd4;
	localparam logic [CFG_IW-1:0] REG_HI = 3'd5;
	localparam logic [CFG_IW-1:0] REG_MAN = 3'd6;
	localparam logic [CFG_IW-1:0] REG_FLAGS = 3'd7;

	localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

	// multiplier operand pairs
	typedef enum logic [2:0] {
		MS_NONE, MS_KC_E, MS_TF_LD, MS_KD_DP, MS_KI_DT, MS_KIDT_ES
	} msel_t;

	typedef enum logic [3:0] {
		ACT_NONE, ACT_LOAD, ACT_HOLD, ACT_CAP_P, ACT_MANUAL, ACT_CAP_TD, ACT_CAP_KD,
		ACT_CAP_KI, ACT_CAP_INC, ACT_DIV_INIT, ACT_DIV_STEP, ACT_CAP_D, ACT_INTEG,
		ACT_FINISH
	} act_t;

	typedef struct packed {
		msel_t msel;
		act_t  act;
	} cmd_t;

	typedef struct packed {
		logic dt_zero;
		logic manual;
		logic div_last;
	} stat_t;

	function automatic logic signed [DW-1:0] sat66(input logic signed [65:0] x);
		logic signed [DW-1:0] r;
		if (x > 66'(SMAX)) r = SMAX;
		else if (x < 66'(SMIN)) r = SMIN;
		else r = x[DW-1:0];
		return r;
	endfunction

	// high limit tested first
	function automatic logic signed [DW-1:0] clamp36(input logic signed [35:0] x,
		input logic signed [DW-1:0] lo, input logic signed [DW-1:0] hi);
		logic signed [DW-1:0] r;
		if (x > 36'(hi)) r = hi;
		else if (x < 36'(lo)) r = lo;
		else r = x[DW-1:0];
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== design/pid_loop_step.sv =====
// pid_loop_step: one sample of a fixed-point PID loop per input beat.
// input channel s_*: setpoint, measured and elapsed time (Q16.16) in s_tdata.
// output channel m_*: clamped drive, clip flag, integrator and clip count.
// configuration: cfg_we writes cfg_data to register cfg_index at the clock edge;
// write only while no sample is in flight.
// results: zero elapsed time gives the quickest result, manual mode the next
// quickest and automatic mode the slowest.
// throughput: one sample at a time; s_tready is high only in the idle state.
// in automatic mode the wait is set by the derivative filter division, a
// restoring divider that retires one quotient bit per cycle over 65 bits, and
// by the five products taken one after another on a single 33x33 multiplier.
// a finished result sits in the output register; the next sample is accepted
// while it waits, and the block stalls only when a second result is ready
// before the first is taken.
// reset (arst_n low): all gains, limits, flags and loop state return to their
// defaults, the output register is emptied and the block is ready at once.
`default_nettype none
module pid_loop_step (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// setpoint[31:0], measured[63:32], elapsed[95:64]
	input  wire logic [pls_pkg::IN_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// drive[31:0], clipped[32], integrator_now[64:33], clip_total[96:65], zero pad
	output logic [pls_pkg::OUT_W-1:0]         m_tdata,
	input  wire logic                         cfg_we,
	input  wire logic [pls_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [pls_pkg::DW-1:0]       cfg_data
);
	pls_pkg::cmd_t cmd;
	pls_pkg::stat_t stat;

	pls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pls_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.m_tdata   (m_tdata)
	);
endmodule
`default_nettype wire

// ===== design/pls_ctrl.sv =====
`default_nettype none
module pls_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	input  wire pls_pkg::stat_t stat,
	output pls_pkg::cmd_t      cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_P, S_MAN, S_TD, S_KD, S_KI, S_INC_M, S_INC,
		S_DIVI, S_DIV, S_CAPD, S_UPD, S_FIN
	} state_t;

	state_t state_q;
	logic out_free;
	logic load_out;

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = (state_q == S_IDLE);
	// the result register takes a new beat on these actions
	assign load_out = (cmd.act == pls_pkg::ACT_HOLD) || (cmd.act == pls_pkg::ACT_MANUAL)
		|| (cmd.act == pls_pkg::ACT_FINISH);

	always_comb begin
		cmd.msel = pls_pkg::MS_NONE;
		cmd.act = pls_pkg::ACT_NONE;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) cmd.act = pls_pkg::ACT_LOAD;
			end
			S_CHECK: begin
				if (stat.dt_zero) begin
					if (out_free) cmd.act = pls_pkg::ACT_HOLD;
				end else begin
					cmd.msel = pls_pkg::MS_KC_E;
				end
			end
			S_P: begin
				cmd.act = pls_pkg::ACT_CAP_P;
				if (!stat.manual) cmd.msel = pls_pkg::MS_TF_LD;
			end
			S_MAN: begin
				if (out_free) cmd.act = pls_pkg::ACT_MANUAL;
			end
			S_TD: begin
				cmd.act = pls_pkg::ACT_CAP_TD;
				cmd.msel = pls_pkg::MS_KD_DP;
			end
			S_KD: begin
				cmd.act = pls_pkg::ACT_CAP_KD;
				cmd.msel = pls_pkg::MS_KI_DT;
			end
			S_KI: cmd.act = pls_pkg::ACT_CAP_KI;
			S_INC_M: cmd.msel = pls_pkg::MS_KIDT_ES;
			S_INC: cmd.act = pls_pkg::ACT_CAP_INC;
			S_DIVI: cmd.act = pls_pkg::ACT_DIV_INIT;
			S_DIV: cmd.act = pls_pkg::ACT_DIV_STEP;
			S_CAPD: cmd.act = pls_pkg::ACT_CAP_D;
			S_UPD: cmd.act = pls_pkg::ACT_INTEG;
			S_FIN: begin
				if (out_free) cmd.act = pls_pkg::ACT_FINISH;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (load_out) m_tvalid <= 1'b1;
			else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: if (s_tvalid) state_q <= S_CHECK;
				S_CHECK: begin
					if (stat.dt_zero) begin
						if (out_free) state_q <= S_IDLE;
					end else begin
						state_q <= S_P;
					end
				end
				S_P: state_q <= stat.manual ? S_MAN : S_TD;
				S_MAN: begin
					if (out_free) state_q <= S_IDLE;
				end
				S_TD: state_q <= S_KD;
				S_KD: state_q <= S_KI;
				S_KI: state_q <= S_INC_M;
				S_INC_M: state_q <= S_INC;
				S_INC: state_q <= S_DIVI;
				S_DIVI: state_q <= S_DIV;
				S_DIV: if (stat.div_last) state_q <= S_CAPD;
				S_CAPD: state_q <= S_UPD;
				S_UPD: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/pls_dpath.sv =====
`default_nettype none
module pls_dpath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [pls_pkg::IN_W-1:0]     s_tdata,
	input  wire logic                         cfg_we,
	input  wire logic [pls_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [pls_pkg::DW-1:0]       cfg_data,
	input  wire pls_pkg::cmd_t                cmd,
	output pls_pkg::stat_t                    stat,
	output logic [pls_pkg::OUT_W-1:0]         m_tdata
);
	localparam int DW = pls_pkg::DW;

	// configuration
	logic signed [DW-1:0] kc_q, ki_q, kd_q, lo_q, hi_q, man_q;
	logic [DW-2:0] tf_q;
	logic [2:0] flags_q;

	// loop state
	logic signed [DW-1:0] integ_q, last_err_q, last_meas_q, last_deriv_q, last_drive_q;
	logic [DW-1:0] clip_cnt_q;

	// per-sample work registers
	logic signed [DW-1:0] e_q, dp_q, pv_q, p_q, kidt_q, inc_q, d_q;
	logic [DW-1:0] dt_q;
	logic signed [65:0] prod_q, num_q;
	logic [64:0] quo_q;
	logic [33:0] rem_q, dvsr_q;
	logic [6:0] dcnt_q;
	logic neg_q;

	// result register
	logic signed [DW-1:0] o_drive_q, o_integ_q;
	logic o_clip_q;
	logic [DW-1:0] o_total_q;

	logic signed [DW-1:0] sp_in, pv_in;
	logic [DW-1:0] dt_in;
	logic sgn_neg;
	logic signed [33:0] diff_e, diff_d;
	logic signed [32:0] mul_a, mul_b;
	logic [33:0] trial;
	logic signed [DW-1:0] dval, integ_new, drive_new;
	logic signed [35:0] tent, mv;
	logic signed [33:0] integ_sum;
	logic go, clipped_new;
	logic [64:0] num_mag;

	assign sp_in = s_tdata[DW-1:0];
	assign pv_in = s_tdata[2*DW-1:DW];
	assign dt_in = s_tdata[3*DW-1:2*DW];
	assign sgn_neg = flags_q[1];

	assign diff_e = sgn_neg ? 34'(pv_in) - 34'(sp_in) : 34'(sp_in) - 34'(pv_in);
	assign diff_d = sgn_neg ? 34'(pv_in) - 34'(last_meas_q) : 34'(last_meas_q) - 34'(pv_in);

	assign stat.dt_zero = (dt_q == '0);
	assign stat.manual = flags_q[0];
	assign stat.div_last = (dcnt_q == 7'd64);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.msel)
			pls_pkg::MS_KC_E: begin
				mul_a = 33'(kc_q);
				mul_b = 33'(e_q);
			end
			pls_pkg::MS_TF_LD: begin
				mul_a = $signed({2'b00, tf_q});
				mul_b = 33'(last_deriv_q);
			end
			pls_pkg::MS_KD_DP: begin
				mul_a = 33'(kd_q);
				mul_b = 33'(dp_q);
			end
			pls_pkg::MS_KI_DT: begin
				mul_a = 33'(ki_q);
				mul_b = $signed({1'b0, dt_q});
			end
			pls_pkg::MS_KIDT_ES: begin
				mul_a = 33'(kidt_q);
				mul_b = 33'(e_q) + 33'(last_err_q);
			end
			default: ;
		endcase
	end

	// one quotient bit a step, on the magnitude
	assign trial = {rem_q[32:0], quo_q[64]};
	assign num_mag = num_q[65] ? 65'(-num_q) : num_q[64:0];

	always_comb begin
		if (!neg_q) dval = (quo_q > 65'h7FFF_FFFF) ? pls_pkg::SMAX : quo_q[DW-1:0];
		else dval = (quo_q > 65'h8000_0000) ? pls_pkg::SMIN : -quo_q[DW-1:0];
	end

	// anti-windup: stop when pushing further into a saturated output
	always_comb begin
		tent = 36'(p_q) + 36'(integ_q) + 36'(inc_q) + 36'(d_q);
		go = !((tent >= 36'(hi_q) && inc_q > 0) || (tent <= 36'(lo_q) && inc_q < 0));
		integ_sum = go ? 34'(integ_q) + 34'(inc_q) : 34'(integ_q);
		integ_new = pls_pkg::clamp36(36'(integ_sum), lo_q, hi_q);
		mv = 36'(p_q) + 36'(integ_q) + 36'(d_q);
		drive_new = pls_pkg::clamp36(mv, lo_q, hi_q);
		clipped_new = (36'(drive_new) != mv);
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.act)
			pls_pkg::ACT_LOAD: begin
				e_q <= pls_pkg::sat66(66'(diff_e));
				dp_q <= pls_pkg::sat66(66'(diff_d));
				pv_q <= pv_in;
				dt_q <= dt_in;
			end
			pls_pkg::ACT_CAP_P: p_q <= pls_pkg::sat66(prod_q >>> pls_pkg::FB);
			pls_pkg::ACT_CAP_TD: num_q <= prod_q;
			pls_pkg::ACT_CAP_KD: num_q <= num_q + prod_q;
			pls_pkg::ACT_CAP_KI: begin
				if (pls_pkg::sat66(prod_q >>> pls_pkg::FB) == pls_pkg::SMIN)
					kidt_q <= -pls_pkg::SMAX;
				else
					kidt_q <= pls_pkg::sat66(prod_q >>> pls_pkg::FB);
			end
			pls_pkg::ACT_CAP_INC: inc_q <= pls_pkg::sat66(prod_q >>> (pls_pkg::FB + 1));
			pls_pkg::ACT_DIV_INIT: begin
				quo_q <= num_mag;
				neg_q <= num_q[65];
				rem_q <= '0;
				dvsr_q <= 34'({1'b0, tf_q}) + 34'(dt_q);
				dcnt_q <= '0;
			end
			pls_pkg::ACT_DIV_STEP: begin
				if (trial >= dvsr_q) begin
					rem_q <= trial - dvsr_q;
					quo_q <= {quo_q[63:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[63:0], 1'b0};
				end
				dcnt_q <= dcnt_q + 7'd1;
			end
			pls_pkg::ACT_CAP_D: d_q <= (kd_q != 0) ? dval : '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kc_q <= 32'sd65536;
			ki_q <= '0;
			kd_q <= '0;
			tf_q <= '0;
			lo_q <= '0;
			hi_q <= 32'sd6553600;
			man_q <= '0;
			flags_q <= '0;
			integ_q <= '0;
			last_err_q <= '0;
			last_meas_q <= '0;
			last_deriv_q <= '0;
			last_drive_q <= '0;
			clip_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pls_pkg::REG_KC: kc_q <= cfg_data;
					pls_pkg::REG_KI: ki_q <= cfg_data;
					pls_pkg::REG_KD: kd_q <= cfg_data;
					pls_pkg::REG_TF: tf_q <= cfg_data[DW-2:0];
					pls_pkg::REG_LO: lo_q <= cfg_data;
					pls_pkg::REG_HI: hi_q <= cfg_data;
					pls_pkg::REG_MAN: man_q <= pls_pkg::clamp36(36'($signed(cfg_data)), lo_q, hi_q);
					pls_pkg::REG_FLAGS: flags_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			case (cmd.act)
				pls_pkg::ACT_MANUAL: begin
					if (ki_q != 0)
						integ_q <= pls_pkg::clamp36(36'(pls_pkg::sat66(66'(man_q) - 66'(p_q))),
							lo_q, hi_q);
					else
						integ_q <= '0;
					last_drive_q <= man_q;
					last_err_q <= e_q;
					last_meas_q <= pv_q;
				end
				pls_pkg::ACT_INTEG: begin
					if (ki_q != 0 && !flags_q[2]) integ_q <= integ_new;
				end
				pls_pkg::ACT_FINISH: begin
					if (clipped_new && clip_cnt_q != '1) clip_cnt_q <= clip_cnt_q + 32'd1;
					last_drive_q <= drive_new;
					last_err_q <= e_q;
					last_meas_q <= pv_q;
					last_deriv_q <= d_q;
				end
				default: ;
			endcase
		end
	end

	// result register, loaded only when the output side is free
	always_ff @(posedge clk) begin
		case (cmd.act)
			pls_pkg::ACT_HOLD: begin
				o_drive_q <= flags_q[0] ? man_q : last_drive_q;
				o_clip_q <= 1'b0;
				o_integ_q <= integ_q;
				o_total_q <= clip_cnt_q;
			end
			pls_pkg::ACT_MANUAL: begin
				o_drive_q <= man_q;
				o_clip_q <= 1'b0;
				o_integ_q <= (ki_q != 0)
					? pls_pkg::clamp36(36'(pls_pkg::sat66(66'(man_q) - 66'(p_q))), lo_q, hi_q)
					: '0;
				o_total_q <= clip_cnt_q;
			end
			pls_pkg::ACT_FINISH: begin
				o_drive_q <= drive_new;
				o_clip_q <= clipped_new;
				o_integ_q <= integ_q;
				o_total_q <= (clipped_new && clip_cnt_q != '1) ? clip_cnt_q + 32'd1 : clip_cnt_q;
			end
			default: ;
		endcase
	end

	assign m_tdata = {7'd0, o_total_q, o_integ_q, o_clip_q, o_drive_q};
endmodule
`default_nettype wire

// ===== design/pls_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module pls_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     s_tvalid,
	input wire logic                     s_tready,
	input wire logic                     m_tvalid,
	input wire logic                     m_tready,
	input wire logic [pls_pkg::OUT_W-1:0] m_tdata
);
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_NEXT(a_data_hold, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	// one sample in flight: ready drops after each input beat
	`ASSERT_NEXT(a_one_sample, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// a clipped beat always shows a nonzero count
	`ASSERT_SAME(a_clip_count, clk, arst_n, m_tvalid && m_tdata[32], m_tdata[96:65] != 32'd0)
endmodule

bind pid_loop_step pls_checker u_pls_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
